/* src/rpfa_pkg.sv */
`default_nettype none

package rpfa_pkg;

   localparam int ADDR_W = 40;
   localparam int REF_W  = 8;
   localparam int DATA_W = 64;
   localparam int PADDR_W = 4;

   localparam logic [ADDR_W-1:0] CSR_ADDR_RESET = 40'h00_8000_0000;

   // register select is paddr[3], registers sit 8 bytes apart
   localparam logic CSR_IDX_REGION_BASE = 1'b0;
   localparam logic CSR_IDX_FIRST_FREE  = 1'b1;

   typedef enum logic [1:0] {
      CMD_ALLOC    = 2'd0,
      CMD_FREE     = 2'd1,
      CMD_ADD_REF  = 2'd2,
      CMD_READ_REF = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STS_OK        = 3'd0,
      STS_NO_MEM    = 3'd1,
      STS_BAD_ADDR  = 3'd2,
      STS_UNDERFLOW = 3'd3,
      STS_SATURATED = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type            command;
      logic [ADDR_W-1:0]  phys_addr;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [ADDR_W-1:0]  page_addr;
      logic [REF_W-1:0]   refcnt;
      logic               released;
   } rsp_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_EXEC
   } state_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic decode;
      logic exec;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
   } ctrl_sts_type;

endpackage

`default_nettype wire

/* src/rpfa_ram.sv */
`default_nettype none

module rpfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/rpfa_ctrl.sv */
`default_nettype none

module rpfa_ctrl
   import rpfa_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   output ctrl_cmd_type      cmd,
   input  wire ctrl_sts_type sts
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
         end
         S_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // the clearing pass only ends on its last entry
   a_clear_exit: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == S_CLEAR && state_ff == S_IDLE) |-> $past(sts.clear_last))
      else $error("clearing pass left early");

endmodule

`default_nettype wire

/* src/rpfa_dpath.sv */
`default_nettype none

module rpfa_dpath
   import rpfa_pkg::*;
#(
   parameter int NUM_PAGES  = 32768,
   parameter int PAGE_SHIFT = 12,
   parameter int COUNT_BITS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ctrl_cmd_type      cmd,
   output ctrl_sts_type           sts,
   input  wire req_type           req_data,
   input  wire logic [ADDR_W-1:0] region_base,
   input  wire logic [ADDR_W-1:0] first_free,
   output logic                   rsp_valid,
   output rsp_type                rsp_data
);

   localparam int IDX_W   = $clog2(NUM_PAGES);
   localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
   localparam logic [ADDR_W:0] SPAN = (ADDR_W+1)'(64'(NUM_PAGES) << PAGE_SHIFT);
   localparam logic [DEPTH_W-1:0] PAGES_D  = DEPTH_W'(NUM_PAGES);
   localparam logic [IDX_W-1:0]   CLR_LAST = IDX_W'(NUM_PAGES - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // latched request
   req_type             req_ff;

   // decode results
   logic                addr_ok_ff, addr_ok_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                ffa_le_ff, ffa_le_in;
   logic [ADDR_W-1:0]   ffa_off_ff, ffa_off_in;

   // allocator state
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [DEPTH_W-1:0]  top_ff, top_in;
   logic [IDX_W-1:0]    clr_ff, clr_in;

   logic                rsp_valid_ff;
   rsp_type             rsp_ff, rsp_in;

   // memory ports
   logic                   cw_en;
   logic [IDX_W-1:0]       cw_addr;
   logic [COUNT_BITS-1:0]  cw_data;
   logic [COUNT_BITS-1:0]  cnt_rd;
   logic                   sw_en;
   logic [IDX_W-1:0]       stack_rd;

   logic [ADDR_W:0]        addr_diff, ffa_diff;
   logic [DEPTH_W-1:0]     depth_m1, top_m1;
   logic [ADDR_W:0]        top_lim;
   logic                   untouched_ok;
   logic [IDX_W-1:0]       alloc_idx;
   logic [ADDR_W-1:0]      page_sum;
   logic [COUNT_BITS-1:0]  cnt_inc, cnt_dec;

   // decode: range and alignment checks, index of the addressed frame
   always_comb begin
      addr_diff  = {1'b0, req_ff.phys_addr} - {1'b0, region_base};
      ffa_diff   = {1'b0, first_free} - {1'b0, region_base};
      addr_ok_in = (req_ff.phys_addr[PAGE_SHIFT-1:0] == '0)
                   && !addr_diff[ADDR_W]
                   && ({1'b0, addr_diff[ADDR_W-1:0]} < SPAN)
                   && !(req_ff.command == CMD_FREE && req_ff.phys_addr < first_free);
      idx_in     = addr_diff[PAGE_SHIFT +: IDX_W];
      ffa_le_in  = ffa_diff[ADDR_W] || (ffa_diff == '0);
      ffa_off_in = ffa_diff[ADDR_W-1:0];
   end

   // execute
   always_comb begin
      depth_m1 = depth_ff - DEPTH_W'(1);
      top_m1   = top_ff - DEPTH_W'(1);
      // top > ceil(off / page) is the same as off <= (top - 1) * page
      top_lim  = (ADDR_W+1)'(top_m1) << PAGE_SHIFT;
      untouched_ok = (top_ff != '0) && (ffa_le_ff || ({1'b0, ffa_off_ff} <= top_lim));
      alloc_idx = (depth_ff != '0) ? stack_rd : top_m1[IDX_W-1:0];
      page_sum  = region_base + (ADDR_W'(alloc_idx) << PAGE_SHIFT);
      cnt_inc   = cnt_rd + COUNT_BITS'(1);
      cnt_dec   = cnt_rd - COUNT_BITS'(1);

      rsp_in   = '0;
      cw_en    = 1'b0;
      cw_addr  = idx_ff;
      cw_data  = '0;
      sw_en    = 1'b0;
      depth_in = depth_ff;
      top_in   = top_ff;
      clr_in   = clr_ff;

      if (cmd.clear) begin
         cw_en   = 1'b1;
         cw_addr = clr_ff;
         clr_in  = clr_ff + IDX_W'(1);
      end

      if (cmd.exec) begin
         if (req_ff.command == CMD_ALLOC) begin
            if (depth_ff != '0 || untouched_ok) begin
               if (depth_ff != '0) begin
                  depth_in = depth_m1;
               end else begin
                  top_in = top_m1;
               end
               cw_en            = 1'b1;
               cw_addr          = alloc_idx;
               cw_data          = COUNT_BITS'(1);
               rsp_in.page_addr = page_sum;
               rsp_in.refcnt    = REF_W'(1);
            end else begin
               rsp_in.status = STS_NO_MEM;
            end
         end else if (!addr_ok_ff) begin
            rsp_in.status = STS_BAD_ADDR;
         end else begin
            case (req_ff.command)
               CMD_FREE: begin
                  if (cnt_rd == '0) begin
                     rsp_in.status = STS_UNDERFLOW;
                  end else begin
                     cw_en         = 1'b1;
                     cw_data       = cnt_dec;
                     rsp_in.refcnt = REF_W'(cnt_dec);
                     if (cnt_dec == '0) begin
                        rsp_in.released = 1'b1;
                        // push onto a full stack is dropped
                        if (depth_ff < PAGES_D) begin
                           sw_en    = 1'b1;
                           depth_in = depth_ff + DEPTH_W'(1);
                        end
                     end
                  end
               end
               CMD_ADD_REF: begin
                  if (cnt_rd == COUNT_MAX) begin
                     rsp_in.status = STS_SATURATED;
                     rsp_in.refcnt = REF_W'(cnt_rd);
                  end else begin
                     cw_en         = 1'b1;
                     cw_data       = cnt_inc;
                     rsp_in.refcnt = REF_W'(cnt_inc);
                  end
               end
               default: begin
                  rsp_in.refcnt = REF_W'(cnt_rd);
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         top_ff       <= PAGES_D;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         top_ff       <= top_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= cmd.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.decode) begin
         addr_ok_ff <= addr_ok_in;
         idx_ff     <= idx_in;
         ffa_le_ff  <= ffa_le_in;
         ffa_off_ff <= ffa_off_in;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   rpfa_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NUM_PAGES)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cw_en),
      .wr_addr (cw_addr),
      .wr_data (cw_data),
      .rd_addr (idx_in),
      .rd_data (cnt_rd)
   );

   rpfa_ram #(
      .WIDTH (IDX_W),
      .DEPTH (NUM_PAGES)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (sw_en),
      .wr_addr (depth_ff[IDX_W-1:0]),
      .wr_data (idx_ff),
      .rd_addr (depth_m1[IDX_W-1:0]),
      .rd_data (stack_rd)
   );

   assign sts.clear_last = (clr_ff == CLR_LAST);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_ff;

   a_bounds: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= PAGES_D && top_ff <= PAGES_D)
      else $error("stack depth or untouched top beyond page count");

   a_strobe_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(cmd.exec))
      else $error("result strobe without an execute cycle");

   a_no_mem: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STS_NO_MEM)
         |-> ($past(depth_ff) == '0 && rsp_ff.page_addr == '0))
      else $error("out of memory with frames on the stack");

   a_released: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.released)
         |-> (rsp_ff.status == STS_OK && rsp_ff.refcnt == '0))
      else $error("frame released with a live count");

endmodule

`default_nettype wire

/* src/refcounted_page_frame_allocator.sv */
// channel    ports                              handshake
// ---------  ---------------------------------  ----------------------------------
// request    start, busy, req_data              taken when start and not busy
// result     rsp_valid, rsp_data                one-cycle strobe, cannot be held off
// csr        csr_psel/penable/pwrite/paddr/...  apb write on access cycle, pready high
//
// each request passes accept, decode (address checks and count ram
// read) and execute (count and stack update); the result strobes in the next cycle
// after reset a clearing pass zeroes the count ram with busy high
// the result side has no stall, results leave in the cycle after execute
`default_nettype none

module refcounted_page_frame_allocator
   import rpfa_pkg::*;
#(
   parameter int NUM_PAGES  = 32768,
   parameter int PAGE_SHIFT = 12,
   parameter int COUNT_BITS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   output rsp_type                 rsp_data,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [PADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0]  csr_pwdata,
   output logic      [DATA_W-1:0]  csr_prdata,
   output logic                    csr_pready
);

   logic [ADDR_W-1:0] region_base_ff, region_base_in;
   logic [ADDR_W-1:0] first_free_ff, first_free_in;
   logic              csr_wr;

   ctrl_cmd_type      cmd;
   ctrl_sts_type      sts;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      region_base_in = region_base_ff;
      first_free_in  = first_free_ff;
      if (csr_wr) begin
         if (csr_paddr[3] == CSR_IDX_FIRST_FREE) begin
            first_free_in = csr_pwdata[ADDR_W-1:0];
         end else begin
            region_base_in = csr_pwdata[ADDR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff <= CSR_ADDR_RESET;
         first_free_ff  <= CSR_ADDR_RESET;
      end else begin
         region_base_ff <= region_base_in;
         first_free_ff  <= first_free_in;
      end
   end

   always_comb begin
      if (csr_paddr[3] == CSR_IDX_REGION_BASE) begin
         csr_prdata = DATA_W'(region_base_ff);
      end else begin
         csr_prdata = DATA_W'(first_free_ff);
      end
   end

   rpfa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   rpfa_dpath #(
      .NUM_PAGES  (NUM_PAGES),
      .PAGE_SHIFT (PAGE_SHIFT),
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_data    (req_data),
      .region_base (region_base_ff),
      .first_free  (first_free_ff),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire
